// ===== rtl/core/rbh_pkg.sv =====
// Shared types, constants and the power-table function for the rubber bearing force block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package rbh_pkg;

	localparam int POWER_TABLE_ENTRIES_DEF = 256;
	localparam int CFG_INDEX_W = 3;

	// constant factors, Q0.32 unless noted
	localparam logic [63:0] K_022     = 64'd944892805;
	localparam logic [63:0] K_020     = 64'd858993459;
	localparam logic [63:0] K_002     = 64'd85899346;
	localparam logic [63:0] K_0016    = 64'd68719477;
	localparam logic [63:0] K_025_Q24 = 64'd4194304;
	localparam logic [63:0] K_18_Q24  = 64'd30198989;
	localparam logic [31:0] TWO_Q24   = 32'd33554432;
	localparam logic [47:0] FORCE_CAP = 48'h8000_0000_0000;

	typedef enum logic [2:0] {
		CFG_DIR_COS      = 3'd0,
		CFG_DIR_SIN      = 3'd1,
		CFG_INV_HEIGHT   = 3'd2,
		CFG_INV_ALPHA    = 3'd3,
		CFG_RADIAL_SCALE = 3'd4,
		CFG_SHEAR_SCALE  = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		SH_24,
		SH_25,
		SH_32
	} shift_t;

	typedef enum logic [3:0] {
		MO_UX, MO_UY, MO_STEP, MO_INTERP, MO_TERM, MO_G, MO_G2, MO_G3,
		MO_TR1, MO_D2, MO_TR2, MO_TS1, MO_TS2, MO_FR, MO_FS1, MO_FS2
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COMMIT, ST_GO, ST_WAIT, ST_DU_CHK, ST_TBL0, ST_TBL1, ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic    load_in;
		logic    mul_start;
		mul_op_t op;
		logic    tbl_lo;
		logic    tbl_hi;
		logic    commit;
		logic    finish;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic du_zero;
		logic cq_zero;
		logic pow_top;
		logic g_gt_18;
	} dp_status_t;

	// floor((2i/(n-1))^0.7 * 2^24): largest y with y^10 * (n-1)^7 <= (2i)^7 * 2^240
	function automatic logic [31:0] pow_entry(input int unsigned i, input int unsigned n);
		logic [383:0] rhs;
		logic [383:0] lhs;
		logic [31:0]  lo;
		logic [31:0]  hi;
		logic [31:0]  mid;
		if (i == 0)
			return 32'd0;
		rhs = 384'd1;
		for (int k = 0; k < 7; k++)
			rhs = rhs * 384'(2 * i);
		rhs = rhs << 240;
		lo = 32'd0;
		hi = 32'd1 << 25;
		for (int it = 0; it < 25; it++) begin
			mid = lo + ((hi - lo) >> 1);
			lhs = 384'd1;
			for (int k = 0; k < 10; k++)
				lhs = lhs * 384'(mid);
			for (int k = 0; k < 7; k++)
				lhs = lhs * 384'(n - 1);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rbh_mul.sv =====
// Shared multiply unit: 64x64 unsigned multiply-shift-saturate over four 33x33 partial
// products, or one signed 33x33 product shifted right by 30. Depends on rbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbh_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            is_signed,
	input  rbh_pkg::shift_t shift,
	input  logic [63:0]     a,
	input  logic [63:0]     b,
	output logic            done,
	output logic [63:0]     res
);
	import rbh_pkg::*;

	logic [63:0]        a_q;
	logic [63:0]        b_q;
	logic               sgn_q;
	shift_t             sh_q;
	logic               busy_q;
	logic               done_q;
	logic [2:0]         cnt_q;
	logic signed [65:0] p_q;
	logic [1:0]         psh_q;
	logic [127:0]       acc_q;

	logic [2:0]         npp;
	logic [1:0]         k;
	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [65:0] prod;
	logic [127:0]       addend;
	logic [127:0]       shifted;

	assign npp = sgn_q ? 3'd1 : 3'd4;
	assign k   = cnt_q[1:0];

	// partial product k: a half k[1], b half k[0], weight 32*(k[1]+k[0])
	always_comb begin
		if (sgn_q) begin
			ma = $signed(a_q[32:0]);
			mb = $signed(b_q[32:0]);
		end else begin
			ma = $signed({1'b0, k[1] ? a_q[63:32] : a_q[31:0]});
			mb = $signed({1'b0, k[0] ? b_q[63:32] : b_q[31:0]});
		end
	end

	assign prod   = ma * mb;
	assign addend = {{62{p_q[65]}}, p_q} << {psh_q, 5'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == npp) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sgn_q <= is_signed;
			sh_q  <= shift;
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (cnt_q < npp) begin
				p_q   <= prod;
				psh_q <= {1'b0, k[1]} + {1'b0, k[0]};
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + addend;
		end
	end

	always_comb begin
		case (sh_q)
			SH_24:   shifted = acc_q >> 24;
			SH_25:   shifted = acc_q >> 25;
			SH_32:   shifted = acc_q >> 32;
			default: shifted = acc_q >> 24;
		endcase
	end

	assign done = done_q;
	assign res  = sgn_q ? acc_q[93:30] : ((|shifted[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF
		: shifted[63:0]);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("multiplier done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiplier restarted while busy");
	a_signed_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && sgn_q |-> cnt_q <= 3'd1) else $error("signed product ran too long");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rbh_dp.sv =====
// Datapath: configuration and state registers, power table, operand selection around the
// shared multiply unit, force assembly and output register. Depends on rbh_pkg, rbh_mul.
`timescale 1ns / 1ps
`default_nettype none

module rbh_dp #(
	parameter int POWER_TABLE_ENTRIES = rbh_pkg::POWER_TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [rbh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic signed [31:0]              rel_disp_x,
	input  logic signed [31:0]              rel_disp_y,
	input  rbh_pkg::dp_cmd_t                cmd,
	output rbh_pkg::dp_status_t             st,
	output logic signed [47:0]              shear_force,
	output logic signed [31:0]              hysteretic_state
);
	import rbh_pkg::*;

	localparam int IDX_W = $clog2(POWER_TABLE_ENTRIES);
	localparam int POS_W = 25 + IDX_W + 1;
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(POWER_TABLE_ENTRIES - 1);

	function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	// configuration
	logic signed [31:0] dir_cos_q;
	logic signed [31:0] dir_sin_q;
	logic [31:0]        inv_height_q;
	logic [31:0]        inv_alpha_q;
	logic [31:0]        radial_scale_q;
	logic [31:0]        shear_scale_q;

	// committed and trial state
	logic signed [31:0] cdisp_q;
	logic signed [31:0] cq_q;
	logic signed [31:0] tdisp_q;
	logic signed [31:0] tq_q;
	logic signed [47:0] lforce_q;

	// working registers
	logic signed [31:0] dx_q;
	logic signed [31:0] dy_q;
	logic signed [34:0] up1_q;
	logic signed [31:0] u_q;
	logic signed [47:0] q_acc_q;
	logic [41:0]        step_q;
	logic [31:0]        pw_q;
	logic [31:0]        y1_q;
	logic [63:0]        g_q;
	logic [63:0]        g2_q;
	logic [63:0]        taur_q;
	logic [63:0]        taus_q;
	logic [63:0]        t_q;
	logic [63:0]        fr_q;
	logic [63:0]        fs_q;
	logic signed [47:0] force_out_q;
	logic signed [31:0] q_out_q;

	// power table
	logic [31:0] pow_tbl [POWER_TABLE_ENTRIES];

	for (genvar gi = 0; gi < POWER_TABLE_ENTRIES; gi++) begin : g_tbl
		localparam logic [31:0] ENTRY = pow_entry(gi, POWER_TABLE_ENTRIES);
		assign pow_tbl[gi] = ENTRY;
	end

	// combinational helpers
	logic signed [32:0]  du;
	logic [32:0]         du_abs;
	logic [31:0]         cq_abs;
	logic [25:0]         x_cl;
	logic [POS_W-1:0]    pos;
	logic [IDX_W-1:0]    idx;
	logic [IDX_W-1:0]    idx_p1;
	logic [24:0]         frac;
	logic signed [31:0]  q_sat;
	logic [31:0]         q_abs;
	logic [31:0]         u_abs;
	logic [63:0]         d_g;
	logic signed [35:0]  usum;
	logic signed [31:0]  u_new;
	logic [47:0]         fr_c;
	logic [47:0]         fs_c;
	logic signed [49:0]  fr_s;
	logic signed [49:0]  fs_s;
	logic signed [49:0]  fsum;
	logic signed [47:0]  force_new;
	logic [63:0]         ma;
	logic [63:0]         mb;
	logic                msgn;
	shift_t              msh;
	logic                mul_done;
	logic [63:0]         mres;

	assign du     = {u_q[31], u_q} - {cdisp_q[31], cdisp_q};
	assign du_abs = du[32] ? 33'(-du) : 33'(du);
	assign cq_abs = cq_q[31] ? 32'(-cq_q) : 32'(cq_q);
	assign x_cl   = (cq_abs > TWO_Q24) ? TWO_Q24[25:0] : cq_abs[25:0];
	assign pos    = POS_W'(x_cl) * POS_W'(IDX_TOP);
	assign idx    = pos[25 +: IDX_W];
	assign frac   = pos[24:0];
	assign idx_p1 = (idx == IDX_TOP) ? idx : idx + 1'b1;

	always_comb begin
		if (q_acc_q > 48'sd2147483647)
			q_sat = 32'h7FFF_FFFF;
		else if (q_acc_q < -48'sd2147483648)
			q_sat = 32'h8000_0000;
		else
			q_sat = q_acc_q[31:0];
	end

	assign q_abs = q_sat[31] ? 32'(-q_sat) : 32'(q_sat);
	assign u_abs = u_q[31] ? 32'(-u_q) : 32'(u_q);
	assign d_g   = g_q - K_18_Q24;

	assign usum = {up1_q[34], up1_q} + {mres[34], mres[34:0]};

	always_comb begin
		if (usum > 36'sd2147483647)
			u_new = 32'h7FFF_FFFF;
		else if (usum < -36'sd2147483648)
			u_new = 32'h8000_0000;
		else
			u_new = usum[31:0];
	end

	assign fr_c = (fr_q > {16'd0, FORCE_CAP}) ? FORCE_CAP : fr_q[47:0];
	assign fs_c = (fs_q > {16'd0, FORCE_CAP}) ? FORCE_CAP : fs_q[47:0];
	assign fr_s = u_q[31] ? -$signed({2'b00, fr_c}) : $signed({2'b00, fr_c});
	assign fs_s = q_sat[31] ? -$signed({2'b00, fs_c}) : $signed({2'b00, fs_c});
	assign fsum = fr_s + fs_s;

	always_comb begin
		if (fsum > $signed({2'b00, FORCE_CAP - 48'd1}))
			force_new = 48'h7FFF_FFFF_FFFF;
		else if (fsum < -$signed({2'b00, FORCE_CAP}))
			force_new = 48'h8000_0000_0000;
		else
			force_new = fsum[47:0];
	end

	// operand selection for the shared multiplier
	always_comb begin
		ma   = 64'd0;
		mb   = 64'd0;
		msgn = 1'b0;
		msh  = SH_24;
		case (cmd.op)
			MO_UX: begin
				ma   = 64'(-{{32{dir_sin_q[31]}}, dir_sin_q});
				mb   = {{32{dx_q[31]}}, dx_q};
				msgn = 1'b1;
			end
			MO_UY: begin
				ma   = {{32{dir_cos_q[31]}}, dir_cos_q};
				mb   = {{32{dy_q[31]}}, dy_q};
				msgn = 1'b1;
			end
			MO_STEP: begin
				ma = {31'd0, du_abs};
				mb = {32'd0, inv_alpha_q};
			end
			MO_INTERP: begin
				ma  = {32'd0, y1_q - pw_q};
				mb  = {39'd0, frac};
				msh = SH_25;
			end
			MO_TERM: begin
				ma = {22'd0, step_q};
				mb = {32'd0, pw_q};
			end
			MO_G: begin
				ma = {32'd0, u_abs};
				mb = {32'd0, inv_height_q};
			end
			MO_G2: begin
				ma = g_q;
				mb = g_q;
			end
			MO_G3: begin
				ma = g2_q;
				mb = g_q;
			end
			MO_TR1: begin
				ma  = g_q;
				mb  = K_022;
				msh = SH_32;
			end
			MO_D2: begin
				ma = d_g;
				mb = d_g;
			end
			MO_TR2: begin
				ma  = t_q;
				mb  = K_020;
				msh = SH_32;
			end
			MO_TS1: begin
				ma  = g_q;
				mb  = K_002;
				msh = SH_32;
			end
			MO_TS2: begin
				ma  = g2_q;
				mb  = K_0016;
				msh = SH_32;
			end
			MO_FR: begin
				ma = {32'd0, radial_scale_q};
				mb = taur_q;
			end
			MO_FS1: begin
				ma = {32'd0, shear_scale_q};
				mb = taus_q;
			end
			MO_FS2: begin
				ma = t_q;
				mb = {32'd0, q_abs};
			end
			default: begin
				ma = 64'd0;
			end
		endcase
	end

	rbh_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mul_start),
		.is_signed (msgn),
		.shift     (msh),
		.a         (ma),
		.b         (mb),
		.done      (mul_done),
		.res       (mres)
	);

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_cos_q      <= 32'sh4000_0000;
			dir_sin_q      <= 32'sh0;
			inv_height_q   <= 32'd16777216;
			inv_alpha_q    <= 32'd23967451;
			radial_scale_q <= 32'd0;
			shear_scale_q  <= 32'd0;
			cdisp_q        <= 32'sh0;
			cq_q           <= 32'sh0;
			tdisp_q        <= 32'sh0;
			tq_q           <= 32'sh0;
			lforce_q       <= 48'sh0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_DIR_COS:      dir_cos_q      <= cfg_data;
					CFG_DIR_SIN:      dir_sin_q      <= cfg_data;
					CFG_INV_HEIGHT:   inv_height_q   <= cfg_data;
					CFG_INV_ALPHA:    inv_alpha_q    <= cfg_data;
					CFG_RADIAL_SCALE: radial_scale_q <= cfg_data;
					CFG_SHEAR_SCALE:  shear_scale_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				cdisp_q <= tdisp_q;
				cq_q    <= tq_q;
			end
			if (cmd.finish) begin
				tdisp_q  <= u_q;
				tq_q     <= q_sat;
				lforce_q <= force_new;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dx_q    <= rel_disp_x;
			dy_q    <= rel_disp_y;
			q_acc_q <= {{16{cq_q[31]}}, cq_q};
		end
		if (cmd.tbl_lo)
			pw_q <= pow_tbl[idx];
		if (cmd.tbl_hi)
			y1_q <= pow_tbl[idx_p1];
		if (mul_done) begin
			case (cmd.op)
				MO_UX:     up1_q <= mres[34:0];
				MO_UY:     u_q <= u_new;
				MO_STEP: begin
					step_q <= mres[41:0];
					if (du[32])
						q_acc_q <= q_acc_q - $signed({6'd0, mres[41:0]});
					else
						q_acc_q <= q_acc_q + $signed({6'd0, mres[41:0]});
				end
				MO_INTERP: pw_q <= pw_q + mres[31:0];
				MO_TERM: begin
					// the power term pulls q back toward zero
					if (cq_q[31])
						q_acc_q <= q_acc_q + $signed({4'd0, mres[43:0]});
					else
						q_acc_q <= q_acc_q - $signed({4'd0, mres[43:0]});
				end
				MO_G:      g_q <= mres;
				MO_G2:     g2_q <= mres;
				MO_G3:     g2_q <= mres;
				MO_TR1:    taur_q <= mres;
				MO_D2:     t_q <= mres;
				MO_TR2:    taur_q <= sat_add(taur_q, mres);
				MO_TS1:    taus_q <= sat_add(K_025_Q24, mres);
				MO_TS2:    taus_q <= sat_add(taus_q, mres);
				MO_FR:     fr_q <= (u_q == 32'sd0) ? 64'd0 : mres;
				MO_FS1:    t_q <= mres;
				MO_FS2:    fs_q <= mres;
				default: ;
			endcase
		end
		if (cmd.commit) begin
			force_out_q <= lforce_q;
			q_out_q     <= tq_q;
		end else if (cmd.finish) begin
			force_out_q <= force_new;
			q_out_q     <= q_sat;
		end
	end

	assign st.mul_done = mul_done;
	assign st.du_zero  = (du == 33'sd0);
	assign st.cq_zero  = (cq_q == 32'sd0);
	assign st.pow_top  = (idx == IDX_TOP);
	assign st.g_gt_18  = (g_q > K_18_Q24);

	assign shear_force      = force_out_q;
	assign hysteretic_state = q_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbh_ctrl.sv =====
// Controller: sequences the multiply steps of a trial update, table reads and commit,
// and owns the input ready and result valid flags. Depends on rbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	output logic                out_valid,
	input  logic                out_ready,
	input  rbh_pkg::dp_status_t st,
	output rbh_pkg::dp_cmd_t    cmd
);
	import rbh_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	mul_op_t     op_q;
	mul_op_t     op_n;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= MO_UX;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			op_q        <= op_n;
			out_valid_q <= (out_valid_q && !out_ready) || cmd.commit || cmd.finish;
		end
	end

	always_comb begin
		state_n       = state_q;
		op_n          = op_q;
		cmd           = '0;
		cmd.op        = op_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (operation) begin
						state_n = ST_COMMIT;
					end else begin
						op_n    = MO_UX;
						state_n = ST_GO;
					end
				end
			end
			ST_COMMIT: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			ST_GO: begin
				cmd.mul_start = 1'b1;
				state_n       = ST_WAIT;
			end
			ST_WAIT: begin
				if (st.mul_done) begin
					state_n = ST_GO;
					case (op_q)
						MO_UX:     op_n = MO_UY;
						MO_UY:     state_n = ST_DU_CHK;
						MO_STEP: begin
							if (st.cq_zero)
								op_n = MO_G;
							else
								state_n = ST_TBL0;
						end
						MO_INTERP: op_n = MO_TERM;
						MO_TERM:   op_n = MO_G;
						MO_G:      op_n = MO_G2;
						MO_G2:     op_n = MO_G3;
						MO_G3:     op_n = MO_TR1;
						MO_TR1:    op_n = st.g_gt_18 ? MO_D2 : MO_TS1;
						MO_D2:     op_n = MO_TR2;
						MO_TR2:    op_n = MO_TS1;
						MO_TS1:    op_n = MO_TS2;
						MO_TS2:    op_n = MO_FR;
						MO_FR:     op_n = MO_FS1;
						MO_FS1:    op_n = MO_FS2;
						MO_FS2:    state_n = ST_FINISH;
						default:   state_n = ST_IDLE;
					endcase
				end
			end
			ST_DU_CHK: begin
				// u is registered now; a zero increment keeps q
				op_n    = st.du_zero ? MO_G : MO_STEP;
				state_n = ST_GO;
			end
			ST_TBL0: begin
				cmd.tbl_lo = 1'b1;
				state_n    = ST_TBL1;
			end
			ST_TBL1: begin
				cmd.tbl_hi = 1'b1;
				op_n       = st.pow_top ? MO_TERM : MO_INTERP;
				state_n    = ST_GO;
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.finish) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transaction");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.mul_done |-> state_q == ST_WAIT)
		else $error("multiplier finished outside wait state");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted transaction dropped");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rubber_bearing_hysteresis_force_top.sv =====
// Trial transaction: from acceptance to result valid, up to 16 passes through the shared
// 33x33 multiplier (a 64-bit multiply is four partial products).
// Commit transaction: result valid once the output register is free. One transaction at a time;
// the next is accepted once the previous result sits in the output register.
// Async reset (arst_n low) restores default configuration, committed and trial state.
`timescale 1ns / 1ps
`default_nettype none

module rubber_bearing_hysteresis_force_top #(
	parameter int POWER_TABLE_ENTRIES = rbh_pkg::POWER_TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic signed [31:0]              rel_disp_x,
	input  logic signed [31:0]              rel_disp_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [47:0]              shear_force,
	output logic signed [31:0]              hysteretic_state,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);
	import rbh_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	rbh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rbh_dp #(
		.POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rel_disp_x       (rel_disp_x),
		.rel_disp_y       (rel_disp_y),
		.cmd              (cmd),
		.st               (st),
		.shear_force      (shear_force),
		.hysteretic_state (hysteretic_state)
	);

endmodule

`default_nettype wire

// ===== tb/rubber_bearing_hysteresis_force_top_tb.sv =====
// Self-checking testbench for the rubber bearing hysteretic force block.
// Needs rbh_pkg and rubber_bearing_hysteresis_force_top; predicts results in a scoreboard class.
`timescale 1ns / 1ps

module rubber_bearing_hysteresis_force_top_tb;
	import rbh_pkg::*;

	localparam int TABLE_N = 256;
	localparam longint unsigned SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint FORCE_LIM = 64'sd140737488355328;
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;
	localparam logic OP_TRIAL = 1'b0;
	localparam logic OP_COMMIT = 1'b1;
	localparam int CYCLE_LIMIT = 600000;

	class bearing_scoreboard;
		longint dcos, dsin;
		longint unsigned hinv, ainv, rscale, sscale;
		longint cdisp, cq, tdisp, tq, lforce;
		bit [31:0] pow_rom[TABLE_N];
		logic [47:0] force_fifo[$];
		logic [31:0] q_fifo[$];
		int errors, checked, trials, commits;

		// largest y with y^10 * (N-1)^7 <= (2i)^7 * 2^240, built one bit at a time
		function bit [31:0] root07(int unsigned i);
			logic [383:0] lim, acc;
			bit [31:0] y, t;
			lim = 384'd1;
			for (int k = 0; k < 7; k++) lim = lim * (2 * i);
			lim = lim << 240;
			y = 0;
			for (int b = 24; b >= 0; b--) begin
				t = y | (32'd1 << b);
				acc = 384'd1;
				for (int k = 0; k < 10; k++) acc = acc * t;
				for (int k = 0; k < 7; k++) acc = acc * (TABLE_N - 1);
				if (acc <= lim) y = t;
			end
			return y;
		endfunction

		function new();
			for (int i = 0; i < TABLE_N; i++) pow_rom[i] = (i == 0) ? 0 : root07(i);
			dcos = 64'sd1073741824; dsin = 0;
			hinv = 16777216; ainv = 23967451; rscale = 0; sscale = 0;
			cdisp = 0; cq = 0; tdisp = 0; tq = 0; lforce = 0;
		endfunction

		function longint unsigned mulf(longint unsigned a, longint unsigned b, int s);
			logic [127:0] p;
			p = (128'(a) * 128'(b)) >> s;
			return (p[127:64] != 0) ? SAT64 : p[63:0];
		endfunction

		function longint unsigned addsat(longint unsigned a, longint unsigned b);
			longint unsigned s;
			s = a + b;
			return (s < a) ? SAT64 : s;
		endfunction

		function longint unsigned pow07(longint unsigned x);
			longint unsigned pos, idx, frac, y0, y1;
			if (x > TWO_Q24) x = TWO_Q24;
			pos = x * (TABLE_N - 1);
			idx = pos >> 25;
			frac = pos & (TWO_Q24 - 1);
			if (idx >= TABLE_N - 1) return pow_rom[TABLE_N - 1];
			y0 = pow_rom[idx];
			y1 = pow_rom[idx + 1];
			return (y1 >= y0) ? y0 + (((y1 - y0) * frac) >> 25) : y0 - (((y0 - y1) * frac) >> 25);
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				CFG_DIR_COS:      dcos = longint'(signed'(d));
				CFG_DIR_SIN:      dsin = longint'(signed'(d));
				CFG_INV_HEIGHT:   hinv = d;
				CFG_INV_ALPHA:    ainv = d;
				CFG_RADIAL_SCALE: rscale = d;
				CFG_SHEAR_SCALE:  sscale = d;
				default: ;
			endcase
		endfunction

		function void note(logic op, logic signed [31:0] dx, logic signed [31:0] dy);
			longint u, du, q, term, frc;
			longint unsigned stp, au, g, g2, g3, taur, taus, fr, fs, aq, d;
			if (op == OP_COMMIT) begin
				cq = tq; cdisp = tdisp; commits++;
			end else begin
				trials++;
				u = ((-dsin * longint'(dx)) >>> 30) + ((dcos * longint'(dy)) >>> 30);
				if (u > 64'sd2147483647) u = 64'sd2147483647;
				if (u < -64'sd2147483648) u = -64'sd2147483648;
				du = u - cdisp;
				q = cq;
				if (du != 0) begin
					stp = mulf((du < 0) ? -du : du, ainv, 24);
					q += (du > 0) ? longint'(stp) : -longint'(stp);
					if (cq != 0) begin
						term = mulf(stp, pow07((cq < 0) ? -cq : cq), 24);
						q += (cq > 0) ? -term : term;
					end
				end
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				au = (u < 0) ? -u : u;
				g = mulf(au, hinv, 24);
				g2 = mulf(g, g, 24);
				g3 = mulf(g2, g, 24);
				taur = mulf(g, K_022, 32);
				if (g > K_18_Q24) begin
					d = g - K_18_Q24;
					taur = addsat(taur, mulf(mulf(d, d, 24), K_020, 32));
				end
				taus = addsat(addsat(K_025_Q24, mulf(g, K_002, 32)), mulf(g3, K_0016, 32));
				fr = (u == 0) ? 0 : mulf(rscale, taur, 24);
				aq = (q < 0) ? -q : q;
				fs = mulf(mulf(sscale, taus, 24), aq, 24);
				if (fr > FORCE_LIM) fr = FORCE_LIM;
				if (fs > FORCE_LIM) fs = FORCE_LIM;
				frc = ((u < 0) ? -longint'(fr) : longint'(fr)) + ((q < 0) ? -longint'(fs) : longint'(fs));
				if (frc > FORCE_LIM - 1) frc = FORCE_LIM - 1;
				if (frc < -FORCE_LIM) frc = -FORCE_LIM;
				tdisp = u; tq = q; lforce = frc;
			end
			force_fifo.push_back(lforce[47:0]);
			q_fifo.push_back(tq[31:0]);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
			errors++;
		endtask

		task check(logic [47:0] f, logic [31:0] q);
			logic [47:0] ef;
			logic [31:0] eq;
			if (force_fifo.size() == 0) begin
				report_mismatch("unexpected result", {16'd0, f}, 64'd0);
			end else begin
				ef = force_fifo.pop_front();
				eq = q_fifo.pop_front();
				if (f !== ef) report_mismatch("shear_force", {16'd0, f}, {16'd0, ef});
				if (q !== eq) report_mismatch("hysteretic_state", {32'd0, q}, {32'd0, eq});
			end
			checked++;
		endtask

		function int pending();
			return force_fifo.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic signed [31:0] rel_disp_x = '0;
	logic signed [31:0] rel_disp_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [47:0] shear_force;
	logic signed [31:0] hysteretic_state;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	bearing_scoreboard sb;
	bit calm = 1'b0;
	int cycles = 0;
	logic signed [31:0] prev_x = '0, prev_y = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rubber_bearing_hysteresis_force_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.rel_disp_x(rel_disp_x), .rel_disp_y(rel_disp_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.shear_force(shear_force), .hysteretic_state(hysteretic_state),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 6);
		if (out_valid && out_ready) sb.check(shear_force, hysteretic_state);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rubber_bearing_hysteresis_force_top_tb: FAIL");
			$finish;
		end
	end

	// leaves cfg_valid high; cfg_end drops it after the last write
	task cfg_write(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
	endtask

	task cfg_end();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task send(logic op, logic signed [31:0] dx, logic signed [31:0] dy);
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rel_disp_x <= dx;
		rel_disp_y <= dy;
		do @(posedge clk); while (!in_ready);
		sb.note(op, dx, dy);
		prev_x = dx;
		prev_y = dy;
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function logic [31:0] rand_dir();
		return 32'($signed({1'b0, $urandom_range(32'h8000_0000, 0)}) - 33'sd1073741824);
	endfunction

	function logic signed [31:0] rand_disp(logic signed [31:0] prev);
		case ($urandom_range(4))
			0: return $urandom;
			1: return $signed($urandom) >>> $urandom_range(14, 3);
			2: return '0;
			3: return prev;
			default: return $signed($urandom) >>> 7;
		endcase
	endfunction

	task set_all(logic [31:0] c, logic [31:0] s, logic [31:0] h, logic [31:0] a,
			logic [31:0] r, logic [31:0] sh);
		cfg_write(CFG_DIR_COS, c);
		cfg_write(CFG_DIR_SIN, s);
		cfg_write(CFG_INV_HEIGHT, h);
		cfg_write(CFG_INV_ALPHA, a);
		cfg_write(CFG_RADIAL_SCALE, r);
		cfg_write(CFG_SHEAR_SCALE, sh);
		cfg_end();
	endtask

	task random_items(int n);
		logic op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(99) < 30) ? OP_COMMIT : OP_TRIAL;
			send(op, (op == OP_COMMIT) ? $urandom : rand_disp(prev_x),
				(op == OP_COMMIT) ? $urandom : rand_disp(prev_y));
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: scales are zero, so only q moves
		send(OP_TRIAL, 32'sd0, 32'sd8388608);
		send(OP_COMMIT, '0, '0);
		drain();

		set_all(32'h4000_0000, 32'h0, 32'h0100_0000, 32'd23967451, 32'd256000, 32'd128000);
		cfg_write(CFG_SPARE_6, $urandom);
		cfg_write(CFG_SPARE_7, $urandom);
		cfg_end();
		send(OP_TRIAL, '0, '0);                   // zero deformation
		send(OP_TRIAL, '0, 32'sd16777216);
		send(OP_COMMIT, 32'h7FFF_FFFF, 32'h8000_0000);
		send(OP_TRIAL, '0, 32'sd16777216);        // same displacement: zero increment
		send(OP_TRIAL, '0, -32'sd33554432);
		send(OP_COMMIT, '0, '0);
		send(OP_TRIAL, '0, 32'sh7FFF_FFFF);
		send(OP_TRIAL, '0, 32'sh8000_0000);
		send(OP_TRIAL, 32'sh7FFF_FFFF, '0);
		drain();

		// huge alpha drives q to saturation, then past 2.0 for the power term
		set_all(32'hC000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_TRIAL, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send(OP_COMMIT, '0, '0);
		send(OP_TRIAL, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(OP_TRIAL, 32'sd1000, '0);
		send(OP_COMMIT, '0, '0);
		send(OP_TRIAL, -32'sd5000, '0);
		send(OP_TRIAL, '0, '0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_all(32'h4000_0000, 32'h0, 32'h0100_0000, 32'd23967451,
						$urandom_range(1 << 24), $urandom_range(1 << 24));
				1: set_all(32'h0, 32'hC000_0000, '0, '0, '0, '0);
				2: set_all(rand_dir(), rand_dir(), $urandom, $urandom, $urandom, $urandom);
				3: set_all(rand_dir(), rand_dir(), $urandom_range(1 << 27),
						$urandom_range(1 << 27), $urandom_range(1 << 28), $urandom_range(1 << 28));
				4: set_all(32'h2D41_3CCD, 32'h2D41_3CCD, 32'h0200_0000, 32'h0300_0000,
						$urandom, $urandom);
				default: set_all(rand_dir(), rand_dir(), $urandom, $urandom, $urandom, $urandom);
			endcase
			calm = (ph == 3);
			random_items(40);
			if (ph == 2) begin
				// let everything come back before resuming
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			random_items(35);
			calm = 1'b0;
			drain();
		end

		repeat (30) @(posedge clk);
		$display("covered %0d trial and %0d commit transactions, %0d results checked",
			sb.trials, sb.commits, sb.checked);
		$display("configuration phases included zero, maximum and rotated axis settings");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("rubber_bearing_hysteresis_force_top_tb: PASS");
		end else begin
			$display("rubber_bearing_hysteresis_force_top_tb: FAIL");
		end
		$finish;
	end

endmodule
